>>> hdl/rrfl_pkg.sv
// Package with the command codes and shared constants of the register renamer.
package rrfl_pkg;

    localparam logic [2:0] CMD_RENAME_DST = 3'd0;
    localparam logic [2:0] CMD_RENAME_SRC = 3'd1;
    localparam logic [2:0] CMD_COMPLETE   = 3'd2;
    localparam logic [2:0] CMD_RETIRE     = 3'd3;
    localparam logic [2:0] CMD_RECOVER    = 3'd4;
    localparam logic [2:0] CMD_QUERY      = 3'd5;
    localparam logic [2:0] CMD_READ_STAT  = 3'd6;
    localparam logic [2:0] CMD_CLEAR_STAT = 3'd7;

    localparam logic [1:0] CFG_SP    = 2'd0;
    localparam logic [1:0] CFG_FLAGS = 2'd1;
    localparam logic [1:0] CFG_IP    = 2'd2;

    localparam logic [5:0] SP_RESET    = 6'd6;
    localparam logic [5:0] FLAGS_RESET = 6'd25;
    localparam logic [5:0] IP_RESET    = 6'd26;

    localparam int          TALLY_W   = 2;
    localparam logic [1:0]  TALLY_MAX = 2'd3;
    localparam int          STAT_W    = 32;

endpackage

>>> hdl/rrfl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module rrfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/register_rename_free_list.sv
// Top level of the register renamer with alias tables and a FIFO free list.
// The tables sit in synchronous RAMs with a registered read and are read, modified, written back.
// An item passes S_RD1 and S_OUT before its result; a mapped source rename or a retire adds
// S_RD2, and a retire that frees a register also S_RD3. The next item is taken with that result
// unless the output stalls. A recover copies the committed map entry by entry through S_RCV_R
// and S_RCV_W. After reset a clearing pass fills the free list and clears all the metadata.
module register_rename_free_list #(
    parameter int ARCH_REGS = 64,
    parameter int PHYS_REGS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_arch_idx,
    input  logic [6:0]  i_preg_idx,
    input  logic        i_producer_known,
    input  logic        i_producer_is_store,
    input  logic        i_producer_is_branch,
    input  logic [1:0]  i_stat_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_preg_out,
    output logic        o_status,
    output logic        o_reg_valid,
    output logic        o_arch_mapped,
    output logic [7:0]  o_free_count,
    output logic [31:0] o_stat_value,
    output logic        o_source_was_new,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    import rrfl_pkg::*;

    localparam int AW  = $clog2(ARCH_REGS);
    localparam int PW  = $clog2(PHYS_REGS);
    localparam int LW  = $clog2(PHYS_REGS + 1);
    localparam int MW  = PW + 1;
    localparam int OW  = AW;
    localparam int MDW = OW + 1 + 1 + TALLY_W;

    // Sequencer states.
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_RD3   = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;
    localparam logic [3:0] S_RCV_R = 4'd6;
    localparam logic [3:0] S_RCV_W = 4'd7;

    typedef struct packed {
        logic [OW-1:0]      owner;
        logic               valid;
        logic               gpr;
        logic [TALLY_W-1:0] tally;
    } t_meta;

    logic [3:0]  r_state, n_state;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_head, r_tail;
    logic [LW-1:0] r_level;
    logic [5:0]  r_sp, r_flags, r_ip;
    logic [STAT_W-1:0] r_hist [4];

    logic [2:0]  r_cmd;
    logic [5:0]  r_arch;
    logic [6:0]  r_phys;
    logic        r_gpr_in;
    logic [1:0]  r_sidx;
    logic [MW-1:0] r_old;
    logic [PW-1:0] r_pop;
    logic [OW-1:0] r_own;

    logic        r_ovalid;
    logic [6:0]  r_o_phys;
    logic        r_o_status, r_o_regv, r_o_mapped, r_o_new;
    logic [31:0] r_o_stat;

    // Memory ports.
    logic          spec_we, com_we, fifo_we, meta_we;
    logic [AW-1:0] spec_wa, spec_ra, com_wa, com_ra;
    logic [MW-1:0] spec_wd, spec_rd, com_wd, com_rd;
    logic [PW-1:0] fifo_wa, fifo_ra, fifo_wd, fifo_rd;
    logic [PW-1:0] meta_wa, meta_ra;
    t_meta         meta_wd, meta_rd;

    // Valid bits of the two maps: an entry not yet written reads unmapped.
    logic [ARCH_REGS-1:0] r_spec_ok, r_com_ok;

    rrfl_ram #(.WIDTH(MW), .DEPTH(ARCH_REGS)) u_spec (
        .i_clk, .i_we(spec_we), .i_waddr(spec_wa), .i_wdata(spec_wd),
        .i_raddr(spec_ra), .o_rdata(spec_rd));
    rrfl_ram #(.WIDTH(MW), .DEPTH(ARCH_REGS)) u_com (
        .i_clk, .i_we(com_we), .i_waddr(com_wa), .i_wdata(com_wd),
        .i_raddr(com_ra), .o_rdata(com_rd));
    rrfl_ram #(.WIDTH(PW), .DEPTH(PHYS_REGS)) u_fifo (
        .i_clk, .i_we(fifo_we), .i_waddr(fifo_wa), .i_wdata(fifo_wd),
        .i_raddr(fifo_ra), .o_rdata(fifo_rd));
    rrfl_ram #(.WIDTH(MDW), .DEPTH(PHYS_REGS)) u_meta (
        .i_clk, .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(meta_ra), .o_rdata(meta_rd));

    logic in_acc, arch_ok, phys_ok;
    logic [MW-1:0] spec_val, com_val;
    logic spec_m, com_m;
    assign o_stall     = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign arch_ok     = ({1'b0, r_arch} < 7'(ARCH_REGS));
    assign phys_ok     = ({1'b0, r_phys} < 8'(PHYS_REGS));
    assign spec_m      = r_spec_ok[r_arch[AW-1:0]] && spec_rd[MW-1];
    assign com_m       = r_com_ok[r_own] && com_rd[MW-1];
    assign spec_val    = spec_rd;
    assign com_val     = com_rd;

    // Sequencer and memory control.
    always_comb begin
        n_state = r_state;
        spec_we = 1'b0; spec_wa = r_arch[AW-1:0]; spec_wd = '0;
        spec_ra = in_acc ? i_arch_idx[AW-1:0] : r_arch[AW-1:0];
        com_we  = 1'b0; com_wa = r_arch[AW-1:0]; com_wd = '0;
        com_ra  = r_own;
        fifo_we = 1'b0; fifo_wa = r_tail; fifo_wd = '0; fifo_ra = r_head;
        meta_we = 1'b0; meta_wa = r_phys[PW-1:0]; meta_wd = meta_rd;
        meta_ra = in_acc ? i_preg_idx[PW-1:0] : r_phys[PW-1:0];
        case (r_state)
            S_INIT: begin
                fifo_we = 1'b1; fifo_wa = r_ptr; fifo_wd = r_ptr;
                meta_we = 1'b1; meta_wa = r_ptr; meta_wd = '0;
                if (r_ptr == PW'(PHYS_REGS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_RECOVER) n_state = S_RCV_R;
                    else n_state = S_RD1;
                end
            end
            S_RD1: begin
                // Reads of spec map, metadata and free list head are available.
                n_state = S_OUT;
                case (r_cmd)
                    CMD_RENAME_DST: begin
                        if (arch_ok && r_level != '0) begin
                            spec_we = 1'b1; spec_wd = {1'b1, fifo_rd};
                            meta_we = 1'b1; meta_wa = fifo_rd;
                            meta_wd = '{owner: r_arch[OW-1:0], valid: 1'b0,
                                        gpr: r_gpr_in, tally: '0};
                        end
                    end
                    CMD_RENAME_SRC: begin
                        if (arch_ok && spec_m) begin
                            meta_ra = spec_val[PW-1:0];
                            n_state = S_RD2;
                        end else if (arch_ok && r_level != '0) begin
                            spec_we = 1'b1; spec_wd = {1'b1, fifo_rd};
                            com_we = 1'b1; com_wd = {1'b1, fifo_rd};
                            meta_we = 1'b1; meta_wa = fifo_rd;
                            meta_wd = '{owner: r_arch[OW-1:0], valid: 1'b1,
                                        gpr: 1'b0, tally: '0};
                        end
                    end
                    CMD_COMPLETE: begin
                        if (phys_ok) begin
                            meta_we = 1'b1; meta_wd.valid = 1'b1;
                        end
                    end
                    CMD_RETIRE: begin
                        if (phys_ok) begin
                            com_ra = meta_rd.owner;
                            n_state = S_RD2;
                        end
                    end
                    default: ;
                endcase
            end
            S_RD2: begin
                if (r_cmd == CMD_RENAME_SRC) begin
                    meta_we = 1'b1; meta_wa = r_pop;
                    if (meta_rd.tally != TALLY_MAX) meta_wd.tally = meta_rd.tally + 1'b1;
                    n_state = S_OUT;
                end else begin
                    // Retire: install in committed map, fetch the old entry's metadata.
                    com_we = 1'b1; com_wa = r_own; com_wd = {1'b1, r_phys[PW-1:0]};
                    if (com_m) begin
                        meta_ra = com_val[PW-1:0];
                        n_state = S_RD3;
                    end else n_state = S_OUT;
                end
            end
            S_RD3: begin
                meta_we = 1'b1; meta_wa = r_old[PW-1:0]; meta_wd = '0;
                if (r_level != LW'(PHYS_REGS)) begin
                    fifo_we = 1'b1; fifo_wd = r_old[PW-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            S_RCV_R: begin
                com_ra = r_ptr[AW-1:0];
                n_state = S_RCV_W;
            end
            S_RCV_W: begin
                spec_we = 1'b1; spec_wa = r_ptr[AW-1:0]; spec_wd = com_rd;
                if (r_ptr[AW-1:0] == AW'(ARCH_REGS - 1)) n_state = S_OUT;
                else n_state = S_RCV_R;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_ptr <= '0; r_head <= '0; r_tail <= '0;
            r_level <= LW'(PHYS_REGS);
            r_sp <= SP_RESET; r_flags <= FLAGS_RESET; r_ip <= IP_RESET;
            for (int k = 0; k < 4; k++) r_hist[k] <= '0;
            r_spec_ok <= '0; r_com_ok <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) r_ptr <= r_ptr + 1'b1;
            if (r_state == S_IDLE) r_ptr <= '0;
            if (r_state == S_RCV_W) begin
                r_ptr <= r_ptr + 1'b1;
                r_spec_ok[r_ptr[AW-1:0]] <= r_com_ok[r_ptr[AW-1:0]];
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SP:    r_sp <= i_cfg_data;
                    CFG_FLAGS: r_flags <= i_cfg_data;
                    CFG_IP:    r_ip <= i_cfg_data;
                    default: ;
                endcase
            end
            if (spec_we && r_state == S_RD1) r_spec_ok[spec_wa] <= 1'b1;
            if (com_we) r_com_ok[com_wa] <= 1'b1;
            if (r_state == S_RD1 && spec_we) begin
                r_head <= r_head + 1'b1; r_level <= r_level - 1'b1;
            end
            if (fifo_we && r_state == S_RD3) begin
                r_tail <= r_tail + 1'b1; r_level <= r_level + 1'b1;
            end
            if (r_state == S_RD3 && meta_rd.gpr) r_hist[meta_rd.tally] <=
                r_hist[meta_rd.tally] + 1'b1;
            if (r_state == S_RD1 && r_cmd == CMD_CLEAR_STAT)
                for (int k = 0; k < 4; k++) r_hist[k] <= '0;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
    end

    // Item capture and result assembly.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_command; r_arch <= i_arch_idx; r_phys <= i_preg_idx;
            r_sidx <= i_stat_index;
            r_gpr_in <= i_producer_known && !i_producer_is_store &&
                        !i_producer_is_branch && i_arch_idx != r_sp &&
                        i_arch_idx != r_flags && i_arch_idx != r_ip;
            r_o_phys <= '0; r_o_status <= 1'b0; r_o_regv <= 1'b0;
            r_o_mapped <= 1'b0; r_o_new <= 1'b0; r_o_stat <= '0;
        end
        if (r_state == S_RD1) begin
            r_pop <= spec_val[PW-1:0];
            r_own <= meta_rd.owner;
            case (r_cmd)
                CMD_RENAME_DST: begin
                    if (arch_ok && r_level == '0) r_o_status <= 1'b1;
                    else if (arch_ok) r_o_phys <= 7'(fifo_rd);
                end
                CMD_RENAME_SRC: begin
                    if (arch_ok && spec_m) r_o_phys <= 7'(spec_val[PW-1:0]);
                    else if (arch_ok && r_level == '0) r_o_status <= 1'b1;
                    else if (arch_ok) begin
                        r_o_phys <= 7'(fifo_rd); r_o_new <= 1'b1;
                    end
                end
                CMD_QUERY: begin
                    r_o_regv <= phys_ok && meta_rd.valid;
                    if (arch_ok && spec_m) begin
                        r_o_mapped <= 1'b1; r_o_phys <= 7'(spec_val[PW-1:0]);
                    end
                end
                CMD_READ_STAT: r_o_stat <= r_hist[r_sidx];
                default: ;
            endcase
        end
        if (r_state == S_RD2) r_old <= com_val;
    end

    assign o_valid          = r_ovalid;
    assign o_preg_out       = r_o_phys;
    assign o_status         = r_o_status;
    assign o_reg_valid      = r_o_regv;
    assign o_arch_mapped    = r_o_mapped;
    assign o_free_count     = 8'(r_level);
    assign o_stat_value     = r_o_stat;
    assign o_source_was_new = r_o_new;

    // The free list level never exceeds the number of physical registers.
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(PHYS_REGS)) else $error("free list overfull");
    // A fresh source register is never reported together with an empty list.
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_source_was_new && o_status)) else $error("bad source result");
    // No item is accepted during the clearing pass.
    a_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> o_stall) else $error("item during clear");
endmodule
